// ----- rtl/core/gb3_pkg.sv -----
`default_nettype none

package gb3_pkg;

  localparam int PIX_W      = 8;
  localparam int DIM_W      = 11;
  localparam int WEIGHT_W   = 16;
  localparam int FRAC_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // line store entry: newest row in the upper byte, the row before it below
  localparam int ENT_W = 2 * PIX_W;

  localparam int SIDE_W   = PIX_W + 2;
  localparam int PROD_C_W = PIX_W + WEIGHT_W;
  localparam int PROD_S_W = SIDE_W + WEIGHT_W;
  localparam int SUM_W    = PROD_S_W + 2;

  localparam int FRAME_DIM_RST = 1024;
  localparam logic [WEIGHT_W-1:0] W_CENTER_RST = 16'd13381;
  localparam logic [WEIGHT_W-1:0] W_EDGE_RST   = 16'd8116;
  localparam logic [WEIGHT_W-1:0] W_CORNER_RST = 16'd4923;

  localparam int OUT_DEPTH = 8;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_WEIGHT_CENTER = 3'd2,
    CFG_WEIGHT_EDGE   = 3'd3,
    CFG_WEIGHT_CORNER = 3'd4
  } cfg_idx_e;

  // one window column, top to bottom
  typedef struct packed {
    logic [PIX_W-1:0] top;
    logic [PIX_W-1:0] mid;
    logic [PIX_W-1:0] bot;
  } col_t;

  typedef struct packed {
    col_t left;
    col_t center;
    col_t right;
  } win_t;

  typedef struct packed {
    logic eof;
    logic eoi;
  } tag_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    tag_t             tag;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/gb3_if.sv -----
`default_nettype none

interface gb3_in_if;
  import gb3_pkg::*;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface gb3_out_if;
  import gb3_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             end_of_frame;
  logic             end_of_item;

  modport source (output valid, output pixel_out, output end_of_frame, output end_of_item,
                  input ready);
  modport sink   (input valid, input pixel_out, input end_of_frame, input end_of_item,
                  output ready);
endinterface

interface gb3_cfg_if;
  import gb3_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/gb3_ram.sv -----
`default_nettype none

module gb3_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_a_i,
  output logic [WIDTH-1:0] rdata_a_o,
  input  logic [AW-1:0]    raddr_b_i,
  output logic [WIDTH-1:0] rdata_b_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_a_q;
  logic [WIDTH-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_a_q <= mem_q[raddr_a_i];
    rd_b_q <= mem_q[raddr_b_i];
  end

  assign rdata_a_o = rd_a_q;
  assign rdata_b_o = rd_b_q;

endmodule

`default_nettype wire

// ----- rtl/core/gb3_filter.sv -----
`default_nettype none

module gb3_filter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  gb3_pkg::win_t                   win_i,
  input  gb3_pkg::tag_t                   tag_i,
  input  logic [gb3_pkg::WEIGHT_W-1:0]    w_center_i,
  input  logic [gb3_pkg::WEIGHT_W-1:0]    w_edge_i,
  input  logic [gb3_pkg::WEIGHT_W-1:0]    w_corner_i,
  output logic                            valid_o,
  output logic [gb3_pkg::PIX_W-1:0]       pixel_o,
  output gb3_pkg::tag_t                   tag_o
);
  import gb3_pkg::*;

  logic                v1_q;
  logic [PIX_W-1:0]    ctr_q;
  logic [SIDE_W-1:0]   side_q;
  logic [SIDE_W-1:0]   corner_q;
  tag_t                tag1_q;

  logic                v2_q;
  logic [PROD_C_W-1:0] pc_q;
  logic [PROD_S_W-1:0] ps_q;
  logic [PROD_S_W-1:0] pk_q;
  tag_t                tag2_q;

  logic [SUM_W-1:0]        sum;
  logic [SUM_W-FRAC_W-1:0] sum_sh;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  // gather the neighbourhood into center, side and corner terms
  always_ff @(posedge clk_i) begin
    ctr_q    <= win_i.center.mid;
    side_q   <= SIDE_W'(win_i.center.top) + SIDE_W'(win_i.center.bot)
              + SIDE_W'(win_i.left.mid) + SIDE_W'(win_i.right.mid);
    corner_q <= SIDE_W'(win_i.left.top) + SIDE_W'(win_i.right.top)
              + SIDE_W'(win_i.left.bot) + SIDE_W'(win_i.right.bot);
    tag1_q   <= tag_i;
  end

  always_ff @(posedge clk_i) begin
    pc_q   <= PROD_C_W'(ctr_q) * PROD_C_W'(w_center_i);
    ps_q   <= PROD_S_W'(side_q) * PROD_S_W'(w_edge_i);
    pk_q   <= PROD_S_W'(corner_q) * PROD_S_W'(w_corner_i);
    tag2_q <= tag1_q;
  end

  // truncate the Q12.16 sum and clamp to a byte
  always_comb begin
    sum     = SUM_W'(pc_q) + SUM_W'(ps_q) + SUM_W'(pk_q);
    sum_sh  = sum[SUM_W-1:FRAC_W];
    pixel_o = (|sum_sh[SUM_W-FRAC_W-1:PIX_W]) ? {PIX_W{1'b1}} : sum_sh[PIX_W-1:0];
  end

  assign valid_o = v2_q;
  assign tag_o   = tag2_q;

endmodule

`default_nettype wire

// ----- rtl/core/gaussian_blur_3x3.sv -----
// 3x3 Gaussian blur, clamp-to-edge, over a raster stream of 8-bit pixels.
// A taken request passes store read and the filter registers into the queue.
// Throughput: one request per cycle while ready is high, set by the single
// read-modify-write pass through the two-row line store; a row-end pixel yields
// two results at once. Reset (async, active low) clears position, drain state, queue and
// config to defaults; the line store is not cleared and needs no clearing pass.
`default_nettype none

module gaussian_blur_3x3 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  gb3_cfg_if.sink    cfg_i,
  gb3_in_if.sink     src_i,
  gb3_out_if.source  dst_o
);
  import gb3_pkg::*;

  localparam int CW        = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int W_M1_RST  = ((MAX_WIDTH < FRAME_DIM_RST) ? MAX_WIDTH : FRAME_DIM_RST) - 1;
  localparam int H_M1_RST  = ((MAX_HEIGHT < FRAME_DIM_RST) ? MAX_HEIGHT : FRAME_DIM_RST) - 1;
  localparam int PW        = $clog2(OUT_DEPTH);
  localparam int CNTW      = $clog2(OUT_DEPTH + 1);
  localparam int RES_LIMIT = OUT_DEPTH - 2;

  // request descriptor carried from accept into the store-read stage
  typedef struct packed {
    logic             drain;
    logic             use_older;
    logic             c0;
    logic             c1;
    logic             out_a;
    logic             out_b;
    logic             last;
    logic [CW-1:0]    col;
    logic [PIX_W-1:0] pixel;
  } s1_t;

  // ---------------------------------------------------------------------------
  // Configuration: keep effective width and height as (size - 1), clamped
  // ---------------------------------------------------------------------------
  logic [CW-1:0]       w_m1_q;
  logic [RW-1:0]       h_m1_q;
  logic [WEIGHT_W-1:0] wc_q, we_q, wk_q;
  logic [31:0]         cfg_dim;
  logic [CW-1:0]       cfg_w_m1;
  logic [RW-1:0]       cfg_h_m1;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_dim = 32'(cfg_i.data[DIM_W-1:0]);
    // zero counts as one, oversize saturates to the maximum
    if (cfg_dim == 32'd0) begin
      cfg_w_m1 = '0;
      cfg_h_m1 = '0;
    end else begin
      cfg_w_m1 = (cfg_dim > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1) : CW'(cfg_dim - 32'd1);
      cfg_h_m1 = (cfg_dim > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1) : RW'(cfg_dim - 32'd1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_m1_q <= CW'(W_M1_RST);
      h_m1_q <= RW'(H_M1_RST);
      wc_q   <= W_CENTER_RST;
      we_q   <= W_EDGE_RST;
      wk_q   <= W_CORNER_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_FRAME_WIDTH:   w_m1_q <= cfg_w_m1;
        CFG_FRAME_HEIGHT:  h_m1_q <= cfg_h_m1;
        CFG_WEIGHT_CENTER: wc_q   <= cfg_i.data[WEIGHT_W-1:0];
        CFG_WEIGHT_EDGE:   we_q   <= cfg_i.data[WEIGHT_W-1:0];
        CFG_WEIGHT_CORNER: wk_q   <= cfg_i.data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Accept stage: walk the raster position, issue store reads
  // ---------------------------------------------------------------------------
  logic [RW-1:0]   in_row_q, in_row_d;
  logic [CW-1:0]   in_col_q, in_col_d;
  logic [CW-1:0]   drain_col_q, drain_col_d;
  logic            drain_pend_q, drain_pend_d;
  logic            drain_top_q, drain_top_d;
  logic            s1_valid_q, s1_valid_d;
  s1_t             s1_q, s1_d;
  logic [CNTW-1:0] res_q, res_d;
  logic [1:0]      n_res;
  logic            in_acc;
  logic            restart;
  logic [RW-1:0]   cur_row;
  logic [CW-1:0]   cur_col;
  logic [CW-1:0]   raddr_a, raddr_b;

  // take a request only while the output queue has room for two more results
  assign src_i.ready = (res_q <= CNTW'(RES_LIMIT));
  assign in_acc      = src_i.valid && src_i.ready;

  always_comb begin
    in_row_d     = in_row_q;
    in_col_d     = in_col_q;
    drain_col_d  = drain_col_q;
    drain_pend_d = drain_pend_q;
    drain_top_d  = drain_top_q;
    s1_valid_d   = 1'b0;
    s1_d         = '0;
    n_res        = 2'd0;

    // a position left beyond the frame by a config change restarts the frame
    restart = (in_col_q > w_m1_q) || (in_row_q > h_m1_q);
    cur_row = restart ? '0 : in_row_q;
    cur_col = restart ? '0 : in_col_q;

    raddr_a = (src_i.cmd == CMD_DRAIN) ? drain_col_q : cur_col;
    raddr_b = (drain_col_q == w_m1_q) ? drain_col_q : drain_col_q + CW'(1);

    if (in_acc) begin
      if (src_i.cmd == CMD_DRAIN) begin
        if (drain_pend_q) begin
          if (drain_col_q > w_m1_q) begin
            // width shrank under the drain: end it quietly
            drain_pend_d = 1'b0;
            drain_col_d  = '0;
          end else begin
            s1_valid_d       = 1'b1;
            s1_d.drain       = 1'b1;
            s1_d.use_older   = drain_top_q;
            s1_d.c0          = (drain_col_q == '0);
            s1_d.last        = (drain_col_q == w_m1_q);
            s1_d.out_a       = 1'b1;
            s1_d.col         = drain_col_q;
            n_res            = 2'd1;
            if (drain_col_q == w_m1_q) begin
              drain_pend_d = 1'b0;
              drain_col_d  = '0;
            end else begin
              drain_col_d  = drain_col_q + CW'(1);
            end
          end
        end
      end else begin
        // a pixel drops any pending drain
        drain_pend_d   = 1'b0;
        drain_col_d    = '0;
        s1_valid_d     = 1'b1;
        s1_d.use_older = (cur_row > RW'(1));
        s1_d.c0        = (cur_col == '0);
        s1_d.c1        = (cur_col == CW'(1));
        s1_d.out_a     = (cur_row != '0) && (cur_col != '0);
        s1_d.out_b     = (cur_row != '0) && (cur_col == w_m1_q);
        s1_d.col       = cur_col;
        s1_d.pixel     = src_i.pixel_in;
        n_res          = 2'(s1_d.out_a) + 2'(s1_d.out_b);
        if (cur_col == w_m1_q) begin
          in_col_d = '0;
          if (cur_row >= h_m1_q) begin
            // frame done: hold the last row for drain
            drain_top_d  = (cur_row != '0);
            drain_pend_d = 1'b1;
            in_row_d     = '0;
          end else begin
            in_row_d = cur_row + RW'(1);
          end
        end else begin
          in_col_d = cur_col + CW'(1);
          in_row_d = cur_row;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Line store: one entry per column, {row r-1, row r-2}; rewritten by each pixel
  // ---------------------------------------------------------------------------
  logic              ram_we;
  logic [ENT_W-1:0]  ram_wdata;
  logic [ENT_W-1:0]  rdata_a, rdata_b;
  logic              fwd_a_q, fwd_b_q;
  logic [ENT_W-1:0]  fwd_data_q;
  logic [ENT_W-1:0]  ent_a, ent_b;

  gb3_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_store (
    .clk_i     (clk_i),
    .we_i      (ram_we),
    .waddr_i   (s1_q.col),
    .wdata_i   (ram_wdata),
    .raddr_a_i (raddr_a),
    .rdata_a_o (rdata_a),
    .raddr_b_i (raddr_b),
    .rdata_b_o (rdata_b)
  );

  // forward the write-back when the next request reads the same column
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_a_q <= 1'b0;
      fwd_b_q <= 1'b0;
    end else begin
      fwd_a_q <= ram_we && (s1_q.col == raddr_a);
      fwd_b_q <= ram_we && (s1_q.col == raddr_b);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= ram_wdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q     <= '0;
      in_col_q     <= '0;
      drain_col_q  <= '0;
      drain_pend_q <= 1'b0;
      drain_top_q  <= 1'b0;
      s1_valid_q   <= 1'b0;
    end else begin
      in_row_q     <= in_row_d;
      in_col_q     <= in_col_d;
      drain_col_q  <= drain_col_d;
      drain_pend_q <= drain_pend_d;
      drain_top_q  <= drain_top_d;
      s1_valid_q   <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
  end

  // ---------------------------------------------------------------------------
  // Window stage: build column vectors, slide the window, pick the taps
  // ---------------------------------------------------------------------------
  col_t cur_vec, rgt_vec, edge_left;
  col_t win1_q, win2_q;
  win_t win_a, win_b;
  tag_t tag_a, tag_b;
  logic va_in, vb_in;

  always_comb begin
    ent_a = fwd_a_q ? fwd_data_q : rdata_a;
    ent_b = fwd_b_q ? fwd_data_q : rdata_b;

    // top row clamps to the middle row at the top of the frame
    cur_vec.top = s1_q.use_older ? ent_a[PIX_W-1:0] : ent_a[ENT_W-1:PIX_W];
    cur_vec.mid = ent_a[ENT_W-1:PIX_W];
    cur_vec.bot = s1_q.drain ? ent_a[ENT_W-1:PIX_W] : s1_q.pixel;

    rgt_vec.top = s1_q.use_older ? ent_b[PIX_W-1:0] : ent_b[ENT_W-1:PIX_W];
    rgt_vec.mid = ent_b[ENT_W-1:PIX_W];
    rgt_vec.bot = ent_b[ENT_W-1:PIX_W];

    ram_we    = s1_valid_q && !s1_q.drain;
    ram_wdata = {s1_q.pixel, ent_a[ENT_W-1:PIX_W]};

    edge_left = s1_q.c0 ? cur_vec : win1_q;

    if (s1_q.drain) begin
      win_a.left   = edge_left;
      win_a.center = cur_vec;
      win_a.right  = rgt_vec;
    end else begin
      win_a.left   = s1_q.c1 ? win1_q : win2_q;
      win_a.center = win1_q;
      win_a.right  = cur_vec;
    end

    // last column of the row: right neighbour clamps to itself
    win_b.left   = edge_left;
    win_b.center = cur_vec;
    win_b.right  = cur_vec;

    tag_a.eof = s1_q.drain && s1_q.last;
    tag_a.eoi = s1_q.drain || !s1_q.out_b;
    tag_b.eof = 1'b0;
    tag_b.eoi = 1'b1;

    va_in = s1_valid_q && s1_q.out_a;
    vb_in = s1_valid_q && s1_q.out_b;
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      win1_q <= cur_vec;
      win2_q <= win1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Weighted sum: two lanes so a row-end pixel delivers both results together
  // ---------------------------------------------------------------------------
  logic             va_out, vb_out;
  logic [PIX_W-1:0] pix_a, pix_b;
  tag_t             tag_a_out, tag_b_out;

  gb3_filter u_lane_a (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (va_in),
    .win_i      (win_a),
    .tag_i      (tag_a),
    .w_center_i (wc_q),
    .w_edge_i   (we_q),
    .w_corner_i (wk_q),
    .valid_o    (va_out),
    .pixel_o    (pix_a),
    .tag_o      (tag_a_out)
  );

  gb3_filter u_lane_b (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (vb_in),
    .win_i      (win_b),
    .tag_i      (tag_b),
    .w_center_i (wc_q),
    .w_edge_i   (we_q),
    .w_corner_i (wk_q),
    .valid_o    (vb_out),
    .pixel_o    (pix_b),
    .tag_o      (tag_b_out)
  );

  // ---------------------------------------------------------------------------
  // Output queue: lane A ahead of lane B; credits cover results in flight
  // ---------------------------------------------------------------------------
  res_t            fifo_q [OUT_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNTW-1:0] cnt_q;
  logic            pop;
  res_t            head;

  assign pop = dst_o.valid && dst_o.ready;

  always_ff @(posedge clk_i) begin
    if (va_out) begin
      fifo_q[wr_ptr_q] <= '{pixel: pix_a, tag: tag_a_out};
    end
    if (vb_out) begin
      fifo_q[va_out ? wr_ptr_q + PW'(1) : wr_ptr_q] <= '{pixel: pix_b, tag: tag_b_out};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
      res_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + PW'(va_out) + PW'(vb_out);
      rd_ptr_q <= rd_ptr_q + PW'(pop);
      cnt_q    <= cnt_q + CNTW'(va_out) + CNTW'(vb_out) - CNTW'(pop);
      res_q    <= res_d;
    end
  end

  assign res_d = res_q + CNTW'(n_res) - CNTW'(pop);

  assign head               = fifo_q[rd_ptr_q];
  assign dst_o.valid        = (cnt_q != '0);
  assign dst_o.pixel_out    = head.pixel;
  assign dst_o.end_of_frame = head.tag.eof;
  assign dst_o.end_of_item  = head.tag.eoi;

endmodule

`default_nettype wire
